>>> hw/rtl/polygon_area_shoelace_assert.svh
// Assertion macros shared by the shoelace area block.
`ifndef POLYGON_AREA_SHOELACE_ASSERT_SVH
`define POLYGON_AREA_SHOELACE_ASSERT_SVH

// Checked at every rising clock edge outside reset.
`define PAS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define PAS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/pas_pkg.sv
package pas_pkg;

   localparam int CoordWidth = 24;
   localparam int ProdWidth  = 2 * CoordWidth;
   localparam int SumWidth   = 64;
   localparam int AreaWidth  = 63;
   localparam int CountWidth = 2;
   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   // Vertex count at which the front stops counting.
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(3);

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [ProdWidth-1:0]  prod_type;
   typedef logic signed [SumWidth-1:0]   sum_type;

   // One classified vertex handed from the front to the back.
   typedef struct packed {
      coord_type prev_x;
      coord_type prev_y;
      coord_type cur_x;
      coord_type cur_y;
      coord_type first_x;
      coord_type first_y;
      logic      has_prev;
      logic      last;
      logic      too_few;
   } entry_type;

endpackage

>>> hw/rtl/pas_front.sv
module pas_front (
   input  logic                    clock,
   input  logic                    reset,
   input  pas_pkg::coord_type      req_vertex_x,
   input  pas_pkg::coord_type      req_vertex_y,
   input  logic                    req_last_vertex,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    push_valid,
   output pas_pkg::entry_type      push_data,
   input  logic                    push_ready
);

   pas_pkg::coord_type first_x_ff, first_x_in;
   pas_pkg::coord_type first_y_ff, first_y_in;
   pas_pkg::coord_type prev_x_ff, prev_x_in;
   pas_pkg::coord_type prev_y_ff, prev_y_in;
   logic [pas_pkg::CountWidth-1:0] count_ff, count_in;
   logic accept;
   logic is_first;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;
   assign is_first   = (count_ff == '0);

   always_comb begin
      push_data.prev_x   = prev_x_ff;
      push_data.prev_y   = prev_y_ff;
      push_data.cur_x    = req_vertex_x;
      push_data.cur_y    = req_vertex_y;
      push_data.first_x  = is_first ? req_vertex_x : first_x_ff;
      push_data.first_y  = is_first ? req_vertex_y : first_y_ff;
      push_data.has_prev = !is_first;
      push_data.last     = req_last_vertex;
      // The count after this vertex is below three when it was below two.
      push_data.too_few  = (count_ff < (pas_pkg::CountMax - pas_pkg::CountWidth'(1)));
   end

   always_comb begin
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      count_in   = count_ff;
      if (accept) begin
         if (req_last_vertex) begin
            first_x_in = '0;
            first_y_in = '0;
            prev_x_in  = '0;
            prev_y_in  = '0;
            count_in   = '0;
         end else begin
            if (is_first) begin
               first_x_in = req_vertex_x;
               first_y_in = req_vertex_y;
            end
            prev_x_in = req_vertex_x;
            prev_y_in = req_vertex_y;
            if (count_ff != pas_pkg::CountMax) begin
               count_in = count_ff + pas_pkg::CountWidth'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         count_ff   <= '0;
      end else begin
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
         count_ff   <= count_in;
      end
   end

endmodule

>>> hw/rtl/pas_queue.sv
module pas_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  pas_pkg::entry_type push_data,
   output logic               push_ready,
   output logic               pop_valid,
   output pas_pkg::entry_type pop_data,
   input  logic               pop_ready
);

   pas_pkg::entry_type slots_ff [pas_pkg::QueueDepth];
   logic [pas_pkg::QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pas_pkg::QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pas_pkg::QueueCntWidth-1:0] count_ff, count_in;
   logic push;
   logic pop;

   assign push_ready = (count_ff != pas_pkg::QueueCntWidth'(pas_pkg::QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   function automatic logic [pas_pkg::QueuePtrWidth-1:0] next_ptr(
      input logic [pas_pkg::QueuePtrWidth-1:0] ptr
   );
      if (ptr == pas_pkg::QueuePtrWidth'(pas_pkg::QueueDepth - 1)) begin
         return '0;
      end
      return ptr + pas_pkg::QueuePtrWidth'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + pas_pkg::QueueCntWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - pas_pkg::QueueCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/pas_back.sv
`include "polygon_area_shoelace_assert.svh"

module pas_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   input  pas_pkg::entry_type            pop_data,
   output logic                          pop_ready,
   output logic [pas_pkg::AreaWidth-1:0] rsp_area,
   output logic                          rsp_too_few_vertices,
   output logic                          rsp_saturated,
   output logic                          rsp_valid,
   input  logic                          rsp_ready
);

   typedef struct packed {
      pas_pkg::sum_type sum;
      logic             sat;
   } sat_sum_type;

   localparam pas_pkg::sum_type SumMax = {1'b0, {(pas_pkg::SumWidth-1){1'b1}}};

   // Multiply stage.
   logic             m_valid_ff, m_valid_in;
   pas_pkg::prod_type p1_ff, p2_ff, p3_ff, p4_ff;
   logic             m_has_prev_ff, m_last_ff, m_too_few_ff;
   // Cross term stage.
   logic             t_valid_ff, t_valid_in;
   pas_pkg::sum_type term1_ff, term2_ff;
   logic             t_last_ff, t_too_few_ff;
   // Accumulator and result register.
   pas_pkg::sum_type acc_ff, acc_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [pas_pkg::AreaWidth-1:0] area_ff, area_in;
   logic             too_few_ff, too_few_in;
   logic             sat_ff, sat_in;

   logic             adv;
   logic             pop;
   logic             finish;
   sat_sum_type      step1;
   sat_sum_type      step2;
   pas_pkg::sum_type mag;

   function automatic sat_sum_type sat_add(
      input pas_pkg::sum_type acc,
      input pas_pkg::sum_type term
   );
      logic signed [pas_pkg::SumWidth:0] wide;
      logic signed [pas_pkg::SumWidth:0] hi;
      logic signed [pas_pkg::SumWidth:0] lo;
      sat_sum_type res;
      wide = {acc[pas_pkg::SumWidth-1], acc} + {term[pas_pkg::SumWidth-1], term};
      hi   = {1'b0, SumMax};
      lo   = -hi;
      if (wide > hi) begin
         res.sum = SumMax;
         res.sat = 1'b1;
      end else if (wide < lo) begin
         res.sum = -SumMax;
         res.sat = 1'b1;
      end else begin
         res.sum = wide[pas_pkg::SumWidth-1:0];
         res.sat = 1'b0;
      end
      return res;
   endfunction

   // The whole back end moves only when the result register can take a new value.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign pop_ready = adv;
   assign pop       = pop_valid && adv;
   assign finish    = adv && t_valid_ff && t_last_ff;

   assign m_valid_in   = adv ? pop : m_valid_ff;
   assign t_valid_in   = adv ? m_valid_ff : t_valid_ff;
   assign rsp_valid_in = adv ? (t_valid_ff && t_last_ff) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         p1_ff <= pas_pkg::prod_type'(pop_data.prev_x) * pas_pkg::prod_type'(pop_data.cur_y);
         p2_ff <= pas_pkg::prod_type'(pop_data.prev_y) * pas_pkg::prod_type'(pop_data.cur_x);
         p3_ff <= pas_pkg::prod_type'(pop_data.cur_x) * pas_pkg::prod_type'(pop_data.first_y);
         p4_ff <= pas_pkg::prod_type'(pop_data.cur_y) * pas_pkg::prod_type'(pop_data.first_x);
         m_has_prev_ff <= pop_data.has_prev;
         m_last_ff     <= pop_data.last;
         m_too_few_ff  <= pop_data.too_few;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && m_valid_ff) begin
         term1_ff <= m_has_prev_ff
            ? pas_pkg::sum_type'(p1_ff) - pas_pkg::sum_type'(p2_ff) : '0;
         term2_ff <= m_last_ff
            ? pas_pkg::sum_type'(p3_ff) - pas_pkg::sum_type'(p4_ff) : '0;
         t_last_ff    <= m_last_ff;
         t_too_few_ff <= m_too_few_ff;
      end
   end

   // The edge term and the closing term saturate one after the other.
   always_comb begin
      step1 = sat_add(acc_ff, term1_ff);
      step2 = sat_add(step1.sum, term2_ff);
      mag   = step2.sum[pas_pkg::SumWidth-1] ? -step2.sum : step2.sum;
   end

   always_comb begin
      acc_in     = acc_ff;
      ovf_in     = ovf_ff;
      area_in    = area_ff;
      too_few_in = too_few_ff;
      sat_in     = sat_ff;
      if (adv && t_valid_ff) begin
         if (t_last_ff) begin
            acc_in     = '0;
            ovf_in     = 1'b0;
            area_in    = t_too_few_ff ? '0 : mag[pas_pkg::AreaWidth-1:0];
            too_few_in = t_too_few_ff;
            sat_in     = ovf_ff || step1.sat || step2.sat;
         end else begin
            acc_in = step1.sum;
            ovf_in = ovf_ff || step1.sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         t_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         m_valid_ff   <= m_valid_in;
         t_valid_ff   <= t_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      area_ff    <= area_in;
      too_few_ff <= too_few_in;
      sat_ff     <= sat_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_area             = area_ff;
   assign rsp_too_few_vertices = too_few_ff;
   assign rsp_saturated        = sat_ff;

   `PAS_ASSERT(a_clear_after_result, clock, reset, finish |=> (acc_ff == '0) && !ovf_ff, "accumulator not cleared after a result")
   `PAS_ASSERT(a_few_means_zero, clock, reset, (rsp_valid && rsp_too_few_vertices) |-> (rsp_area == '0) && !rsp_saturated, "short polygon with nonzero area or saturation")
   `PAS_ASSERT_ALWAYS(a_acc_symmetric, clock, reset || (acc_ff != {1'b1, {(pas_pkg::SumWidth-1){1'b0}}}), "accumulator reached the most negative value")

endmodule

>>> hw/rtl/polygon_area_shoelace.sv
// Shoelace polygon area.
// Vertices arrive on the req_ channel as signed Q16.8 x,y coordinates, one item
// per vertex, with req_last_vertex set on the final vertex of a polygon. Each item
// is accepted when req_valid and req_ready are both high at a rising clock edge.
// For every polygon one item leaves on the rsp_ channel: the area as an unsigned
// value with 17 fraction bits, a flag for polygons of fewer than three vertices
// (area zero), and a flag that tells that the 64-bit cross product sum saturated.
// Throughput is one vertex per cycle while the back end is not stalled. The last
// vertex of a polygon passes through the queue, the product registers and the
// cross term registers before the accumulator updates the result register. The
// front keeps the first and previous vertex, the back does the four multiplies
// and the saturating sums.
// A two-entry queue separates the front from the back. While a result waits and
// the receiver holds rsp_ready low the back end stops, the queue fills and
// req_ready falls once it is full; nothing is lost. A synchronous reset empties
// the queue and the pipeline and clears all vertex and accumulator state.
module polygon_area_shoelace (
   input  logic                          clock,
   input  logic                          reset,
   input  pas_pkg::coord_type            req_vertex_x,
   input  pas_pkg::coord_type            req_vertex_y,
   input  logic                          req_last_vertex,
   input  logic                          req_valid,
   output logic                          req_ready,
   output logic [pas_pkg::AreaWidth-1:0] rsp_area,
   output logic                          rsp_too_few_vertices,
   output logic                          rsp_saturated,
   output logic                          rsp_valid,
   input  logic                          rsp_ready
);

   logic               push_valid;
   logic               push_ready;
   pas_pkg::entry_type push_data;
   logic               pop_valid;
   logic               pop_ready;
   pas_pkg::entry_type pop_data;

   // The front tags each vertex with its neighbors and its place in the polygon.
   pas_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_vertex_x    (req_vertex_x),
      .req_vertex_y    (req_vertex_y),
      .req_last_vertex (req_last_vertex),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .push_valid      (push_valid),
      .push_data       (push_data),
      .push_ready      (push_ready)
   );

   pas_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // The back computes the cross terms and owns the accumulator and result register.
   pas_back u_back (
      .clock                (clock),
      .reset                (reset),
      .pop_valid            (pop_valid),
      .pop_data             (pop_data),
      .pop_ready            (pop_ready),
      .rsp_area             (rsp_area),
      .rsp_too_few_vertices (rsp_too_few_vertices),
      .rsp_saturated        (rsp_saturated),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready)
   );

endmodule

>>> tb/sv/polygon_area_shoelace_checker.sv
module polygon_area_shoelace_checker
   import pas_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  coord_type            req_vertex_x,
   input  coord_type            req_vertex_y,
   input  logic                 req_last_vertex,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [AreaWidth-1:0] rsp_area,
   input  logic                 rsp_too_few_vertices,
   input  logic                 rsp_saturated,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   output int                   mismatch_count,
   output int                   awaited_count,
   output int                   checked_count,
   output int                   short_count,
   output int                   clamped_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [AreaWidth-1:0] area;
      logic                 too_few;
      logic                 saturated;
   } area_result_type;

   // Largest magnitude the sum may hold, one bit wider than the sum itself.
   localparam logic signed [SumWidth:0] SumCeil = {2'b00, {(SumWidth - 1){1'b1}}};

   area_result_type expected_areas[$];

   coord_type             first_x;
   coord_type             first_y;
   coord_type             prev_x;
   coord_type             prev_y;
   sum_type               cross_sum;
   logic [CountWidth-1:0] vertex_seen;
   logic                  clamp_seen;

   function automatic sum_type cross_of(coord_type ax, coord_type ay,
                                        coord_type bx, coord_type by);
      sum_type wide_ax;
      sum_type wide_ay;
      sum_type wide_bx;
      sum_type wide_by;
      wide_ax = ax;
      wide_ay = ay;
      wide_bx = bx;
      wide_by = by;
      return wide_ax * wide_by - wide_ay * wide_bx;
   endfunction

   task automatic add_clamped(sum_type term);
      logic signed [SumWidth:0] total;
      total = cross_sum + term;
      if (total > SumCeil) begin
         cross_sum  = SumCeil[SumWidth-1:0];
         clamp_seen = 1'b1;
      end else if (total < -SumCeil) begin
         total      = -SumCeil;
         cross_sum  = total[SumWidth-1:0];
         clamp_seen = 1'b1;
      end else begin
         cross_sum = total[SumWidth-1:0];
      end
   endtask

   task automatic clear_polygon();
      first_x     = '0;
      first_y     = '0;
      prev_x      = '0;
      prev_y      = '0;
      cross_sum   = '0;
      vertex_seen = '0;
      clamp_seen  = 1'b0;
   endtask

   task automatic absorb_vertex(coord_type x, coord_type y, logic last);
      area_result_type outcome;
      sum_type         magnitude;
      if (vertex_seen == '0) begin
         first_x = x;
         first_y = y;
      end else begin
         add_clamped(cross_of(prev_x, prev_y, x, y));
      end
      prev_x = x;
      prev_y = y;
      if (vertex_seen < CountMax) begin
         vertex_seen = vertex_seen + 1'b1;
      end
      if (last) begin
         add_clamped(cross_of(x, y, first_x, first_y));
         if (vertex_seen < CountMax) begin
            outcome.area    = '0;
            outcome.too_few = 1'b1;
         end else begin
            magnitude       = (cross_sum < 0) ? -cross_sum : cross_sum;
            outcome.area    = magnitude[AreaWidth-1:0];
            outcome.too_few = 1'b0;
         end
         outcome.saturated = clamp_seen;
         expected_areas.push_back(outcome);
         clear_polygon();
      end
   endtask

   task automatic flag_mismatch(string detail);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] %s", $realtime, detail);
      end
   endtask

   always @(posedge clock) begin : watch_channels
      area_result_type oldest;
      if (reset) begin
         clear_polygon();
         expected_areas.delete();
      end else begin
         // Results are compared before the vertex of this edge is absorbed; the
         // block cannot answer a vertex in the cycle it takes it.
         if (rsp_valid && rsp_ready) begin
            if (expected_areas.size() == 0) begin
               flag_mismatch($sformatf("result with no polygon pending: area %h few %b sat %b",
                                       rsp_area, rsp_too_few_vertices, rsp_saturated));
            end else begin
               oldest = expected_areas.pop_front();
               checked_count++;
               if (oldest.too_few) short_count++;
               if (oldest.saturated) clamped_count++;
               if (rsp_area !== oldest.area || rsp_too_few_vertices !== oldest.too_few ||
                   rsp_saturated !== oldest.saturated) begin
                  flag_mismatch($sformatf(
                     "area %h few %b sat %b, expected area %h few %b sat %b",
                     rsp_area, rsp_too_few_vertices, rsp_saturated,
                     oldest.area, oldest.too_few, oldest.saturated));
               end
            end
         end
         if (req_valid && req_ready) begin
            absorb_vertex(req_vertex_x, req_vertex_y, req_last_vertex);
         end
      end
      awaited_count = expected_areas.size();
   end

endmodule

>>> tb/sv/polygon_area_shoelace_tb.sv
module polygon_area_shoelace_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pas_pkg::*;

   // Coordinate extremes of the signed Q16.8 vertex fields.
   localparam coord_type CoordMin = {1'b1, {(CoordWidth - 1){1'b0}}};
   localparam coord_type CoordMax = {1'b0, {(CoordWidth - 1){1'b1}}};

   // Number of vertices in the random part of the run.
   localparam int RandomVertices = 1050;
   // Length of the long receiver hold-off that fills the block.
   localparam int HoldCycles = 400;
   // Cycles with no item accepted on either side before the run is abandoned.
   localparam int StallLimit = 4000;
   // Margin after the last awaited result, to catch stray results.
   localparam int DrainCycles = 16;

   logic                 clock;
   logic                 reset = 1'b1;
   coord_type            req_vertex_x = '0;
   coord_type            req_vertex_y = '0;
   logic                 req_last_vertex = 1'b0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [AreaWidth-1:0] rsp_area;
   logic                 rsp_too_few_vertices;
   logic                 rsp_saturated;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;

   int mismatch_count;
   int awaited_count;
   int checked_count;
   int short_count;
   int clamped_count;

   // Stimulus bookkeeping and the knobs that shape idling on both sides.
   int vertex_total = 0;
   int polygon_total = 0;
   bit sender_eager = 1'b0;
   bit receiver_eager = 1'b0;
   bit hold_request = 1'b0;

   polygon_area_shoelace dut (
      .clock                (clock),
      .reset                (reset),
      .req_vertex_x         (req_vertex_x),
      .req_vertex_y         (req_vertex_y),
      .req_last_vertex      (req_last_vertex),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .rsp_area             (rsp_area),
      .rsp_too_few_vertices (rsp_too_few_vertices),
      .rsp_saturated        (rsp_saturated),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready)
   );

   polygon_area_shoelace_checker area_check (
      .clock                (clock),
      .reset                (reset),
      .req_vertex_x         (req_vertex_x),
      .req_vertex_y         (req_vertex_y),
      .req_last_vertex      (req_last_vertex),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .rsp_area             (rsp_area),
      .rsp_too_few_vertices (rsp_too_few_vertices),
      .rsp_saturated        (rsp_saturated),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .mismatch_count       (mismatch_count),
      .awaited_count        (awaited_count),
      .checked_count        (checked_count),
      .short_count          (short_count),
      .clamped_count        (clamped_count)
   );

   // 2 ns clock, low for the first half of each period.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Coordinates lean on the two extremes and on small values near the origin,
   // with the rest drawn over the whole field so every bit toggles.
   function automatic coord_type rand_coord();
      int near;
      near = int'($urandom_range(0, 2000)) - 1000;
      case ($urandom_range(0, 9))
         0: return CoordMin;
         1: return CoordMax;
         2, 3, 4: return coord_type'(near);
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Offers one vertex. The task is entered at a falling edge and returns at the
   // falling edge after the item was taken, with req_valid still high, so that a
   // following item with no gap keeps valid up without a glitch.
   task automatic send_vertex(input coord_type x, input coord_type y, input logic last);
      int gap;
      gap = sender_eager ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_vertex_x    = x;
      req_vertex_y    = y;
      req_last_vertex = last;
      req_valid       = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      vertex_total++;
      if (last) polygon_total++;
   endtask

   // One lap around the full-range square. Counterclockwise laps add to the
   // sum, clockwise laps take from it.
   task automatic send_square_lap(input logic clockwise, input logic close);
      send_vertex(CoordMin, CoordMin, 1'b0);
      send_vertex(clockwise ? CoordMin : CoordMax, clockwise ? CoordMax : CoordMin, 1'b0);
      send_vertex(CoordMax, CoordMax, 1'b0);
      send_vertex(clockwise ? CoordMax : CoordMin, clockwise ? CoordMin : CoordMax, close);
   endtask

   // Most polygons have three to eight vertices; a few are degenerate (one or
   // two vertices) and a few are long enough to keep the count saturated.
   task automatic send_random_polygon(output int sent);
      int size;
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) size = 1;
      else if (pick == 1) size = 2;
      else if (pick <= 14) size = $urandom_range(3, 8);
      else if (pick <= 18) size = $urandom_range(9, 20);
      else size = $urandom_range(21, 60);
      for (int i = 0; i < size; i++) begin
         send_vertex(rand_coord(), rand_coord(), i == size - 1);
      end
      sent = size;
   endtask

   // The receiver draws a wait before each result item. When the stimulus asks
   // for it, it instead holds rsp_ready low for a long stretch, counted here, so
   // that the queue inside the block fills and req_ready drops.
   initial begin : receiver
      int gap;
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready = 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_request = 1'b0;
         end
         gap = receiver_eager ? 0 : $urandom_range(0, 5);
         if (gap != 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid && !hold_request);
         @(negedge clock);
      end
   end

   // Ends the run if neither channel moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (reset) @(posedge clock);
      while (quiet < StallLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("No item moved on either channel for %0d cycles.", StallLimit);
      $display("polygon_area_shoelace_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      int random_sent;
      int sent;
      bit held;
      random_sent = 0;
      held = 1'b0;

      repeat (12) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed polygons. A lone vertex closes onto itself and gives zero.
      send_vertex('0, '0, 1'b1);
      send_vertex(CoordMin, CoordMax, 1'b1);
      // Two vertices are still too few, even at the extremes.
      send_vertex(CoordMax, CoordMax, 1'b0);
      send_vertex(CoordMin, CoordMin, 1'b1);
      // Largest triangles, in both winding directions.
      send_vertex(CoordMin, CoordMin, 1'b0);
      send_vertex(CoordMax, CoordMin, 1'b0);
      send_vertex(CoordMax, CoordMax, 1'b1);
      send_vertex(CoordMin, CoordMin, 1'b0);
      send_vertex(CoordMax, CoordMax, 1'b0);
      send_vertex(CoordMax, CoordMin, 1'b1);
      // Three points on one line enclose nothing.
      send_vertex(-coord_type'(256), -coord_type'(256), 1'b0);
      send_vertex('0, '0, 1'b0);
      send_vertex(coord_type'(256), coord_type'(256), 1'b1);
      // Smallest nonzero area, one least significant bit of the result.
      send_vertex('0, '0, 1'b0);
      send_vertex(coord_type'(1), '0, 1'b0);
      send_vertex('0, coord_type'(1), 1'b1);
      // The full-range square, counterclockwise and then clockwise.
      send_square_lap(1'b0, 1'b1);
      send_square_lap(1'b1, 1'b1);

      // Random polygons. Every few polygons the idling on each side may switch
      // between random gaps and none at all.
      while (random_sent < RandomVertices) begin
         if ($urandom_range(0, 7) == 0) sender_eager = ~sender_eager;
         if ($urandom_range(0, 7) == 0) receiver_eager = ~receiver_eager;
         if (!held && random_sent >= RandomVertices / 2) begin
            // Ask for the long hold-off and keep offering small polygons back to
            // back so that results pile up inside the block and its input stalls.
            held = 1'b1;
            sender_eager = 1'b1;
            hold_request = 1'b1;
            for (int i = 0; i < 12; i++) begin
               send_vertex(rand_coord(), rand_coord(), 1'b0);
               send_vertex(rand_coord(), rand_coord(), 1'b0);
               send_vertex(rand_coord(), rand_coord(), 1'b1);
            end
            random_sent += 36;
            sender_eager = 1'b0;
         end
         send_random_polygon(sent);
         random_sent += sent;
      end
      req_valid = 1'b0;

      // Wait for every predicted area, then a little longer to catch strays.
      while (awaited_count != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      $display("Sent %0d vertices in %0d polygons, from lone points to full-range squares.",
               vertex_total, polygon_total);
      $display("Checked %0d areas (%0d too short, %0d saturated) with %0d mismatches.",
               checked_count, short_count, clamped_count, mismatch_count);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("polygon_area_shoelace_tb: PASS");
      end else begin
         $display("polygon_area_shoelace_tb: FAIL");
      end
      $finish;
   end

endmodule
